/* hw/rtl/rrd_pkg.sv */
`timescale 1ns / 1ps

package rrd_pkg;

  // sizes
  localparam int MAX_COLUMNS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int NULL_W          = 16;
  localparam int CNT_CFG_W       = 5;
  localparam int TYPES_W         = 48;
  localparam int CFG_DATA_W      = 48;

  // configuration register indexes
  localparam logic REG_COLUMN_COUNT = 1'b0;
  localparam logic REG_COLUMN_TYPES = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_VALUE   = 2'd0;
  localparam logic [1:0] KIND_STRBYTE = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // end status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_MISMATCH    = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
  localparam logic [1:0] ST_TRUNCATED   = 2'd3;

  // column type codes
  localparam logic [2:0] TY_BOOL    = 3'd0;
  localparam logic [2:0] TY_INT32   = 3'd1;
  localparam logic [2:0] TY_INT64   = 3'd2;
  localparam logic [2:0] TY_FLOAT   = 3'd3;
  localparam logic [2:0] TY_DOUBLE  = 3'd4;
  localparam logic [2:0] TY_VARCHAR = 3'd5;
  localparam logic [2:0] TY_CHAR    = 3'd6;
  localparam logic [2:0] TY_UNSUP   = 3'd7;

  typedef enum logic [2:0] {
    PH_CNT0    = 3'd0,
    PH_CNT1    = 3'd1,
    PH_BITMAP  = 3'd2,
    PH_FIXED   = 3'd3,
    PH_STRLEN  = 3'd4,
    PH_STRDATA = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rrd_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  column;
    logic        is_null;
    logic [63:0] value;
    logic [15:0] string_length;
    logic [1:0]  status;
    logic        last;
  } rrd_out_t;

  // work for the back end: one leading result, a run of null columns, one end status
  typedef struct packed {
    logic        head_valid;
    logic [1:0]  head_kind;
    logic [3:0]  head_column;
    logic [63:0] head_value;
    logic [15:0] head_length;
    logic [4:0]  walk_start;
    logic [4:0]  walk_end;
    logic        tail_valid;
    logic [1:0]  tail_status;
  } rrd_cmd_t;

  // 3-bit type of one column
  function automatic logic [2:0] col_type(input logic [TYPES_W-1:0] types,
                                          input logic [3:0] idx);
    return types[6'(idx) * 6'd3 +: 3];
  endfunction

  // byte width of a fixed-size column type
  function automatic logic [3:0] fixed_width(input logic [2:0] t);
    logic [3:0] w;
    case (t)
      TY_BOOL:  w = 4'd1;
      TY_INT32: w = 4'd4;
      TY_FLOAT: w = 4'd4;
      default:  w = 4'd8;
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/record_row_decoder_unit.sv */
`timescale 1ns / 1ps

// channel   direction  transaction when          payload
// in_       input      in_push && !in_full       rrd_in_t: data_byte, last_byte
// out_      output     out_pop && !out_empty     rrd_out_t: kind .. last
// cfg_      input      cfg_we                    cfg_index selects register, cfg_data
//
// one row byte is accepted per cycle while in_full is low; the front parser updates
// its state in that cycle; the back end delivers one result per cycle from the output
// register while out_pop drains it, so a byte that causes k results keeps the back end
// busy and the queue absorbs the difference; in_full rises when the queue fills
// synchronous active-low reset; no clearing pass, the block is ready right after reset

module record_row_decoder_unit #(
  parameter int MAX_COLUMNS = rrd_pkg::MAX_COLUMNS_DEF,
  parameter int QUEUE_DEPTH = rrd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  rrd_pkg::rrd_in_t               in_data,
  output logic                           out_empty,
  input  logic                           out_pop,
  output rrd_pkg::rrd_out_t              out_data,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [rrd_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic              f_push, f_full;
  rrd_pkg::rrd_cmd_t f_data;
  logic              b_pop, b_valid;
  rrd_pkg::rrd_cmd_t b_data;

  // byte parser
  rrd_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_push   (f_push),
    .q_data   (f_data),
    .q_full   (f_full)
  );

  // work queue between parser and result side
  rrd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_data(f_data),
    .full     (f_full),
    .pop      (b_pop),
    .pop_valid(b_valid),
    .pop_data (b_data)
  );

  // result expansion
  rrd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (b_valid),
    .q_data   (b_data),
    .q_pop    (b_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

endmodule

/* hw/rtl/rrd_front.sv */
`timescale 1ns / 1ps

module rrd_front #(
  parameter int MAX_COLUMNS = rrd_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  rrd_pkg::rrd_in_t                in_data,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [rrd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            q_push,
  output rrd_pkg::rrd_cmd_t               q_data,
  input  logic                            q_full
);

  localparam logic [4:0]  MAXC5  = 5'(MAX_COLUMNS);
  localparam logic [15:0] MAXC16 = 16'(MAX_COLUMNS);

  // configuration
  logic [rrd_pkg::CNT_CFG_W-1:0] column_count_r;
  logic [rrd_pkg::TYPES_W-1:0]   column_types_r;

  // parse state
  rrd_pkg::phase_t             phase_r, phase_nxt;
  logic [3:0]                  byte_index_r, byte_index_nxt;
  logic [4:0]                  column_index_r, column_index_nxt;
  logic [63:0]                 assembled_r, assembled_nxt;
  logic [rrd_pkg::NULL_W-1:0]  null_bits_r, null_bits_nxt;
  logic [15:0]                 string_remaining_r, string_remaining_nxt;
  logic [15:0]                 row_count_r, row_count_nxt;

  // decode results for the byte at the input
  logic                        in_accept;
  logic [7:0]                  b;
  logic                        lastb;
  logic [3:0]                  bi_inc;
  logic [63:0]                 asm_new;
  logic [15:0]                 rc_new;
  logic [15:0]                 rem_new;
  logic [rrd_pkg::NULL_W-1:0]  null_merged;
  logic [rrd_pkg::NULL_W-1:0]  null_cur;
  logic [2:0]                  cur_type;
  logic [15:0]                 lim;
  logic [16:0]                 bitmap_need;
  logic                        head_v;
  logic [1:0]                  head_kind;
  logic [63:0]                 head_val;
  logic [15:0]                 head_len;
  logic                        adv;
  logic [4:0]                  adv_from;
  logic                        fin;
  logic [1:0]                  fin_status;
  logic                        found;
  logic [3:0]                  found_col;
  logic [2:0]                  found_type;
  logic [4:0]                  walk_end;
  logic                        ended;
  logic [1:0]                  end_status;
  logic                        tail_v;
  logic [1:0]                  tail_status;

  assign in_accept = in_push && !q_full;
  assign in_full   = q_full;
  assign b         = in_data.data_byte;
  assign lastb     = in_data.last_byte;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      column_types_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rrd_pkg::REG_COLUMN_COUNT: column_count_r <= cfg_data[rrd_pkg::CNT_CFG_W-1:0];
        rrd_pkg::REG_COLUMN_TYPES: column_types_r <= cfg_data[rrd_pkg::TYPES_W-1:0];
        default: ;
      endcase
    end
  end

  // byte assembly helpers
  assign bi_inc      = byte_index_r + 4'd1;
  assign asm_new     = assembled_r | (64'(b) << {byte_index_r[2:0], 3'b000});
  assign rc_new      = {b, row_count_r[7:0]};
  assign rem_new     = string_remaining_r - 16'd1;
  assign null_merged = null_bits_r |
                       ({{(rrd_pkg::NULL_W-8){1'b0}}, b} << {byte_index_r[0], 3'b000});
  assign null_cur    = (phase_r == rrd_pkg::PH_BITMAP) ? null_merged : null_bits_r;
  assign cur_type    = rrd_pkg::col_type(column_types_r, column_index_r[3:0]);
  assign lim         = (row_count_r < MAXC16) ? row_count_r : MAXC16;
  assign bitmap_need = (17'(row_count_r) + 17'd7) >> 3;

  // classify the byte by phase
  always_comb begin
    head_v     = 1'b0;
    head_kind  = rrd_pkg::KIND_VALUE;
    head_val   = '0;
    head_len   = '0;
    adv        = 1'b0;
    adv_from   = column_index_r + 5'd1;
    fin        = 1'b0;
    fin_status = rrd_pkg::ST_OK;
    case (phase_r)
      rrd_pkg::PH_CNT1: begin
        if (rc_new != 16'(column_count_r) || column_count_r > MAXC5) begin
          fin        = 1'b1;
          fin_status = rrd_pkg::ST_MISMATCH;
        end else if (rc_new == 16'd0) begin
          fin = 1'b1;
        end
      end
      rrd_pkg::PH_BITMAP: begin
        adv_from = 5'd0;
        adv      = (17'(bi_inc) >= bitmap_need);
      end
      rrd_pkg::PH_FIXED: begin
        if (bi_inc >= rrd_pkg::fixed_width(cur_type)) begin
          head_v   = 1'b1;
          head_val = (cur_type == rrd_pkg::TY_BOOL) ? 64'(asm_new != 64'd0) : asm_new;
          adv      = 1'b1;
        end
      end
      rrd_pkg::PH_STRLEN: begin
        if (bi_inc >= 4'd2) begin
          head_v   = 1'b1;
          head_len = asm_new[15:0];
          adv      = (asm_new[15:0] == 16'd0);
        end
      end
      rrd_pkg::PH_STRDATA: begin
        head_v    = 1'b1;
        head_kind = rrd_pkg::KIND_STRBYTE;
        head_val  = 64'(b);
        adv       = (rem_new == 16'd0);
      end
      default: ;
    endcase
  end

  // first non-null column at or after adv_from
  always_comb begin
    found     = 1'b0;
    found_col = '0;
    for (int i = rrd_pkg::NULL_W - 1; i >= 0; i--) begin
      if ((5'(i) >= adv_from) && (16'(i) < lim) && !null_cur[i]) begin
        found     = 1'b1;
        found_col = 4'(i);
      end
    end
  end

  assign found_type = rrd_pkg::col_type(column_types_r, found_col);
  assign walk_end   = found ? {1'b0, found_col} : lim[4:0];

  // row end: explicit finish, end of columns, unsupported type, or truncation
  assign ended       = fin || (adv && (!found || found_type == rrd_pkg::TY_UNSUP));
  assign end_status  = fin ? fin_status :
                       (!found ? rrd_pkg::ST_OK : rrd_pkg::ST_UNSUPPORTED);
  assign tail_v      = (phase_r != rrd_pkg::PH_DONE) && (ended || lastb);
  assign tail_status = ended ? end_status : rrd_pkg::ST_TRUNCATED;

  // next state
  always_comb begin
    phase_nxt            = phase_r;
    byte_index_nxt       = byte_index_r;
    column_index_nxt     = column_index_r;
    assembled_nxt        = assembled_r;
    null_bits_nxt        = null_bits_r;
    string_remaining_nxt = string_remaining_r;
    row_count_nxt        = row_count_r;
    case (phase_r)
      rrd_pkg::PH_CNT0: begin
        byte_index_nxt       = '0;
        column_index_nxt     = '0;
        assembled_nxt        = '0;
        null_bits_nxt        = '0;
        string_remaining_nxt = '0;
        row_count_nxt        = 16'(b);
        phase_nxt            = rrd_pkg::PH_CNT1;
      end
      rrd_pkg::PH_CNT1: begin
        row_count_nxt = rc_new;
        if (!fin) begin
          phase_nxt      = rrd_pkg::PH_BITMAP;
          byte_index_nxt = '0;
        end
      end
      rrd_pkg::PH_BITMAP: begin
        null_bits_nxt  = null_merged;
        byte_index_nxt = bi_inc;
      end
      rrd_pkg::PH_FIXED: begin
        assembled_nxt  = asm_new;
        byte_index_nxt = bi_inc;
      end
      rrd_pkg::PH_STRLEN: begin
        assembled_nxt  = asm_new;
        byte_index_nxt = bi_inc;
        if (bi_inc >= 4'd2) begin
          string_remaining_nxt = asm_new[15:0];
          assembled_nxt        = '0;
          byte_index_nxt       = '0;
          if (asm_new[15:0] != 16'd0) begin
            phase_nxt = rrd_pkg::PH_STRDATA;
          end
        end
      end
      rrd_pkg::PH_STRDATA: begin
        string_remaining_nxt = rem_new;
      end
      default: begin
        if (lastb) begin
          phase_nxt = rrd_pkg::PH_CNT0;
        end
      end
    endcase
    // move on to the next column that carries data
    if (adv) begin
      column_index_nxt = walk_end;
      if (found && found_type != rrd_pkg::TY_UNSUP) begin
        byte_index_nxt = '0;
        assembled_nxt  = '0;
        phase_nxt = (found_type == rrd_pkg::TY_VARCHAR || found_type == rrd_pkg::TY_CHAR) ?
                    rrd_pkg::PH_STRLEN : rrd_pkg::PH_FIXED;
      end
    end
    // close the row
    if (tail_v) begin
      byte_index_nxt       = '0;
      column_index_nxt     = '0;
      assembled_nxt        = '0;
      null_bits_nxt        = '0;
      string_remaining_nxt = '0;
      phase_nxt            = lastb ? rrd_pkg::PH_CNT0 : rrd_pkg::PH_DONE;
    end
  end

  // work handed to the back end
  always_comb begin
    q_data.head_valid  = head_v;
    q_data.head_kind   = head_kind;
    q_data.head_column = column_index_r[3:0];
    q_data.head_value  = head_val;
    q_data.head_length = head_len;
    q_data.walk_start  = adv ? adv_from : 5'd0;
    q_data.walk_end    = adv ? walk_end : 5'd0;
    q_data.tail_valid  = tail_v;
    q_data.tail_status = tail_status;
    q_push = in_accept && (head_v || tail_v || (adv && adv_from < walk_end));
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r            <= rrd_pkg::PH_CNT0;
      byte_index_r       <= '0;
      column_index_r     <= '0;
      assembled_r        <= '0;
      null_bits_r        <= '0;
      string_remaining_r <= '0;
      row_count_r        <= '0;
    end else if (in_accept) begin
      phase_r            <= phase_nxt;
      byte_index_r       <= byte_index_nxt;
      column_index_r     <= column_index_nxt;
      assembled_r        <= assembled_nxt;
      null_bits_r        <= null_bits_nxt;
      string_remaining_r <= string_remaining_nxt;
      row_count_r        <= row_count_nxt;
    end
  end

  // truncation status only on the final byte of the buffer
  a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_data.tail_valid && !ended |-> lastb)
    else $error("truncation status without final byte");

  // bitmap phase only with a valid column count
  a_bitmap_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rrd_pkg::PH_BITMAP |-> (row_count_r != 16'd0 && row_count_r <= MAXC16))
    else $error("bitmap phase with bad column count");

endmodule

/* hw/rtl/rrd_queue.sv */
`timescale 1ns / 1ps

module rrd_queue #(
  parameter int DEPTH = rrd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rrd_pkg::rrd_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output rrd_pkg::rrd_cmd_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rrd_pkg::rrd_cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign full      = (count_r == CNT_FULL);
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

endmodule

/* hw/rtl/rrd_back.sv */
`timescale 1ns / 1ps

module rrd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  rrd_pkg::rrd_cmd_t  q_data,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output rrd_pkg::rrd_out_t  out_data
);

  // work entry being expanded
  logic              head_v_r, head_v_nxt;
  logic [1:0]        head_kind_r;
  logic [3:0]        head_col_r;
  logic [63:0]       head_val_r;
  logic [15:0]       head_len_r;
  logic [4:0]        cur_r, cur_nxt;
  logic [4:0]        end_r;
  logic              tail_v_r, tail_v_nxt;
  logic [1:0]        tail_status_r;

  // output register
  logic              out_valid_r;
  rrd_pkg::rrd_out_t out_r;

  logic              walking;
  logic              busy;
  logic              room;
  logic              step;
  logic              last_piece;
  logic              load;
  rrd_pkg::rrd_out_t res;

  assign walking   = (cur_r < end_r);
  assign busy      = head_v_r || walking || tail_v_r;
  assign room      = !out_valid_r || out_pop;
  assign step      = busy && room;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  // pick the next result of the entry
  always_comb begin
    res        = '0;
    head_v_nxt = head_v_r;
    cur_nxt    = cur_r;
    tail_v_nxt = tail_v_r;
    if (head_v_r) begin
      res.kind          = head_kind_r;
      res.column        = head_col_r;
      res.value         = head_val_r;
      res.string_length = head_len_r;
      head_v_nxt        = 1'b0;
    end else if (walking) begin
      res.kind    = rrd_pkg::KIND_VALUE;
      res.column  = cur_r[3:0];
      res.is_null = 1'b1;
      cur_nxt     = cur_r + 5'd1;
    end else begin
      res.kind   = rrd_pkg::KIND_END;
      res.status = tail_status_r;
      res.last   = 1'b1;
      tail_v_nxt = 1'b0;
    end
    last_piece = !head_v_nxt && !(cur_nxt < end_r) && !tail_v_nxt;
  end

  assign load  = q_valid && (!busy || (step && last_piece));
  assign q_pop = load;

  // work entry registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      tail_v_r <= 1'b0;
      cur_r    <= '0;
      end_r    <= '0;
    end else if (load) begin
      head_v_r <= q_data.head_valid;
      tail_v_r <= q_data.tail_valid;
      cur_r    <= q_data.walk_start;
      end_r    <= q_data.walk_end;
    end else if (step) begin
      head_v_r <= head_v_nxt;
      tail_v_r <= tail_v_nxt;
      cur_r    <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      head_kind_r   <= q_data.head_kind;
      head_col_r    <= q_data.head_column;
      head_val_r    <= q_data.head_value;
      head_len_r    <= q_data.head_length;
      tail_status_r <= q_data.tail_status;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= end_r)
    else $error("null walk past its end");

  a_load_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind == rrd_pkg::KIND_END |-> out_r.last && out_r.column == 4'd0)
    else $error("malformed row end result");

endmodule
